// ===== rtl/core/unsr_pkg.sv =====
// Package for the unsigned-to-radix-string block: widths, codes, shared types
// and the alphabet lookup function.
// No dependencies.
package unsr_pkg;

    localparam int VALUE_W     = 64;
    localparam int CHAR_W      = 8;
    localparam int BASE_LEN_W  = 5;
    localparam int MAX_BASE    = 16;
    localparam int DIGIT_W     = 4;
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = 6;
    localparam int CNT_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int REM_W       = DIGIT_W + 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_LENGTH = 2'd0,
        CFG_ALPHA_LOW   = 2'd1,
        CFG_ALPHA_HIGH  = 2'd2
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_RD,
        S_LD,
        S_OUT
    } seq_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Character of one digit index; 0..7 from the low word, 8..15 from the high word
    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [DIGIT_W-1:0]    idx
    );
        logic [CFG_DATA_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

// ===== rtl/core/unsr_if.sv =====
// Channel interfaces of the unsigned-to-radix-string block: input request and
// digit result, each with valid/ready handshake. Depends on unsr_pkg.
interface unsr_in_if;
    import unsr_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface unsr_out_if;
    import unsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              bad_base;

    modport source (output valid, output digit_char, output last_digit, output bad_base,
                    input ready);
    modport sink   (input valid, input digit_char, input last_digit, input bad_base,
                    output ready);
endinterface

// ===== rtl/core/unsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module unsr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/unsr_abc.sv =====
// Alphabet checker: flags a base length outside 2..MAX_BASE or a repeated
// character among the used digits. Registered flag. Depends on unsr_pkg.
module unsr_abc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [unsr_pkg::BASE_LEN_W-1:0]   base_length,
    input  logic [unsr_pkg::CFG_DATA_W-1:0]   alphabet_low,
    input  logic [unsr_pkg::CFG_DATA_W-1:0]   alphabet_high,
    output logic                              bad
);
    import unsr_pkg::*;

    logic dup;
    logic bad_next;
    logic bad_reg;

    // Pairwise compare of all used characters
    always_comb
    begin
        dup = 1'b0;
        for (int a = 0; a < MAX_BASE; a++)
        begin
            for (int b = a + 1; b < MAX_BASE; b++)
            begin
                if ((BASE_LEN_W'(b) < base_length) &&
                    (alpha_char(alphabet_low, alphabet_high, DIGIT_W'(a)) ==
                     alpha_char(alphabet_low, alphabet_high, DIGIT_W'(b))))
                begin
                    dup = 1'b1;
                end
            end
        end
        bad_next = dup || (base_length < BASE_LEN_W'(2)) ||
                   (base_length > BASE_LEN_W'(MAX_BASE));
    end

    // Reset config (length 10, all-zero alphabet) has duplicates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg <= 1'b1;
        end
        else
        begin
            bad_reg <= bad_next;
        end
    end

    assign bad = bad_reg;

endmodule

// ===== rtl/core/unsr_div.sv =====
// Bit-serial restoring divider: 64-bit dividend by a radix of up to 16,
// one quotient bit per cycle. Depends on unsr_pkg.
module unsr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [unsr_pkg::VALUE_W-1:0]     dividend,
    input  logic [unsr_pkg::BASE_LEN_W-1:0]  divisor,
    output unsr_pkg::div_stat_t              stat,
    output logic [unsr_pkg::VALUE_W-1:0]     quotient,
    output logic [unsr_pkg::DIGIT_W-1:0]     remainder
);
    import unsr_pkg::*;

    localparam int BIT_CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0]   q_reg,    q_next;
    logic [DIGIT_W-1:0]   rem_reg,  rem_next;
    logic [BIT_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     rem_sub;
    logic                 q_bit;

    // One shift-compare-subtract step
    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[VALUE_W-1]};
        q_bit   = (rem_sh >= divisor);
        rem_sub = rem_sh - divisor;

        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[VALUE_W-2:0], q_bit};
            rem_next = q_bit ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
            cnt_next = cnt_reg + BIT_CNT_W'(1);
            if (cnt_reg == BIT_CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Quotient and remainder (remaining quotient clears at reset)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= '0;
            rem_reg <= '0;
        end
        else
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && divisor > BASE_LEN_W'(1)) |=> (rem_reg < divisor))
        else $error("partial remainder not below divisor");
`endif

endmodule

// ===== rtl/core/unsigned_to_radix_string.sv =====
// Top level of the unsigned-to-radix-string block: configuration registers,
// sequencer, digit store. Depends on unsr_pkg, unsr_if, unsr_ram, unsr_abc, unsr_div.
//
// Converts one 64-bit unsigned request into its digits in the radix set by the
// configured alphabet (register 0 is the length, registers 1 and 2 hold up to
// 16 one-byte characters), emitting digit characters most significant first
// with last_digit on the final one; zero gives one digit. A length outside
// 2..16 or a repeated character yields a single result with bad_base set and
// digit_char zero. One request is handled at a time and in_chan.ready is low
// until its last result is taken. Each of up to 64 digits is computed in the
// shared bit-serial divider, which produces one quotient bit per cycle, and is
// then read back from the digit store and presented.
module unsigned_to_radix_string (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [unsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [unsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    unsr_in_if.sink                          in_chan,
    unsr_out_if.source                       out_chan
);
    import unsr_pkg::*;

    seq_state_t               state_reg, state_next;
    logic [BASE_LEN_W-1:0]    base_len_reg;
    logic [CFG_DATA_W-1:0]    alo_reg;
    logic [CFG_DATA_W-1:0]    ahi_reg;
    logic [VALUE_W-1:0]       value_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CHAR_W-1:0]        char_reg;
    logic                     last_reg;
    logic                     bad_reg;

    logic                     bad_flag;
    logic                     div_start;
    logic [VALUE_W-1:0]       dividend;
    div_stat_t                div_stat;
    logic [VALUE_W-1:0]       div_quot;
    logic [DIGIT_W-1:0]       div_rem;
    logic                     ram_we;
    logic                     ram_re;
    logic [STORE_AW-1:0]      ram_raddr;
    logic [DIGIT_W-1:0]       ram_rdata;
    logic [CNT_W-1:0]         n_dec;
    logic                     load_err;
    logic                     load_dig;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg <= BASE_LEN_W'(10);
            alo_reg      <= '0;
            ahi_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE_LENGTH: base_len_reg <= cfg_data[BASE_LEN_W-1:0];
                CFG_ALPHA_LOW:   alo_reg      <= cfg_data;
                CFG_ALPHA_HIGH:  ahi_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    unsr_abc u_abc (
        .clk           (clk),
        .rst_n         (rst_n),
        .base_length   (base_len_reg),
        .alphabet_low  (alo_reg),
        .alphabet_high (ahi_reg),
        .bad           (bad_flag)
    );

    assign dividend = (state_reg == S_CHK) ? value_reg : div_quot;

    unsr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (base_len_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Digit store, least significant digit at address 0
    assign n_dec     = n_reg - CNT_W'(1);
    assign ram_raddr = n_dec[STORE_AW-1:0];

    unsr_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (n_reg[STORE_AW-1:0]),
        .wdata (div_rem),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: next state and controls
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        div_start  = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        load_err   = 1'b0;
        load_dig   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_chan.valid)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (bad_flag)
                begin
                    load_err   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    n_next     = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    ram_we = 1'b1;
                    n_next = n_reg + CNT_W'(1);
                    if ((div_quot != '0) && (n_reg < CNT_W'(STORE_DEPTH - 1)))
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_LD;
            end
            S_LD:
            begin
                load_dig   = 1'b1;
                n_next     = n_dec;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_chan.ready)
                begin
                    state_next = last_reg ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and digit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            value_reg <= in_chan.value;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_err)
        begin
            char_reg <= '0;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
        else if (load_dig)
        begin
            char_reg <= alpha_char(alo_reg, ahi_reg, ram_rdata);
            last_reg <= (n_reg == CNT_W'(1));
            bad_reg  <= 1'b0;
        end
    end

    assign in_chan.ready       = (state_reg == S_IDLE);
    assign out_chan.valid      = (state_reg == S_OUT);
    assign out_chan.digit_char = char_reg;
    assign out_chan.last_digit = last_reg;
    assign out_chan.bad_base   = bad_reg;

`ifndef SYNTHESIS
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && bad_reg) |-> (last_reg && char_reg == '0))
        else $error("error result not a single zero character");
    a_more_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && !last_reg) |-> (n_reg != '0))
        else $error("digits pending but count is zero");
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (n_reg < CNT_W'(STORE_DEPTH)))
        else $error("digit count beyond store depth");
`endif

endmodule
